[design/grfp_pkg.sv]
// Shared types, constants and the CRC byte fold for the guard record frame packer.
// No dependencies; every other design file imports this package.
package grfp_pkg;

    localparam int MAX_ROWS_DEF = 16;

    localparam int HDR_BYTES = 4;
    localparam int REC_BYTES = 24;
    localparam int REC_BITS  = REC_BYTES * 8;
    localparam int IDX_W     = $clog2(REC_BYTES);
    localparam int SIZE_W    = 13;                 // 4 + 24 * 255 fits
    localparam int OFF_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_COUNT    = 2'd1;
    localparam logic [1:0] STAT_CAPACITY = 2'd2;
    localparam logic [1:0] STAT_MISMATCH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd2;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_CLOSE  = 1'b1;

    typedef enum logic [1:0] {
        CMD_ERROR,
        CMD_ROW,
        CMD_HEADER
    } cmd_kind_t;

    typedef struct packed {
        logic        req_type;
        logic [63:0] key_low;
        logic [15:0] key_high;
        logic [7:0]  action_code;
        logic        lockout_flag;
        logic [15:0] cooldown_seconds;
        logic [7:0]  hourly_cap;
        logic [7:0]  window_fired;
        logic [31:0] window_start_time;
        logic [31:0] last_fire_time;
    } in_item_t;

    typedef struct packed {
        logic [8:0] byte_offset;
        logic [7:0] byte_value;
        logic [1:0] status;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [7:0] row_count;
        logic [7:0] format_id;
        logic [9:0] buffer_capacity;
    } cfg_t;

    // One classified request: what the back end has to emit.
    typedef struct packed {
        cmd_kind_t           kind;
        logic                start;    // frame opens here: seed CRC with count byte
        logic [1:0]          status;
        logic [OFF_W-1:0]    base;
        logic [REC_BITS-1:0] record;   // byte i in bits 8i+7:8i
    } cmd_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[design/grfp_front.sv]
// Front end: accepts requests, checks limits and row bookkeeping, builds commands.
// Depends on grfp_pkg.
module grfp_front
    import grfp_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     cfg_clear,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_payload,
    output logic     push,
    input  logic     push_ready,
    output cmd_t     push_cmd
);

    logic [7:0]        rows_written_reg, rows_written_next;
    logic              started_reg, started_next;
    logic [SIZE_W-1:0] frame_size;
    logic [SIZE_W-1:0] base_full;
    logic              accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;
    assign push    = accept;

    assign frame_size = SIZE_W'(HDR_BYTES) + SIZE_W'(cfg.row_count) * SIZE_W'(REC_BYTES);
    assign base_full  = SIZE_W'(HDR_BYTES) + SIZE_W'(rows_written_reg) * SIZE_W'(REC_BYTES);

    always_comb begin
        push_cmd.kind   = CMD_ERROR;
        push_cmd.start  = !started_reg;
        push_cmd.status = STAT_OK;
        push_cmd.base   = base_full[OFF_W-1:0];
        push_cmd.record = {s_payload.last_fire_time, s_payload.window_start_time,
                           s_payload.window_fired, s_payload.hourly_cap,
                           s_payload.cooldown_seconds, 7'd0, s_payload.lockout_flag,
                           s_payload.action_code, s_payload.key_high, s_payload.key_low};
        rows_written_next = rows_written_reg;
        started_next      = started_reg;

        if (cfg.row_count > 8'(MAX_ROWS)) begin
            push_cmd.status = STAT_COUNT;
        end else if (frame_size > SIZE_W'(cfg.buffer_capacity)) begin
            push_cmd.status = STAT_CAPACITY;
        end else if (s_payload.req_type == REQ_CLOSE) begin
            if (rows_written_reg != cfg.row_count) begin
                push_cmd.status = STAT_MISMATCH;
            end else begin
                push_cmd.kind = CMD_HEADER;
                if (accept) begin
                    rows_written_next = 8'd0;
                    started_next      = 1'b0;
                end
            end
        end else if (rows_written_reg >= cfg.row_count) begin
            push_cmd.status = STAT_MISMATCH;
        end else begin
            push_cmd.kind = CMD_ROW;
            if (accept) begin
                rows_written_next = rows_written_reg + 8'd1;
                started_next      = 1'b1;
            end
        end

        if (cfg_clear) begin
            rows_written_next = 8'd0;
            started_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_written_reg <= 8'd0;
            started_reg      <= 1'b0;
        end else begin
            rows_written_reg <= rows_written_next;
            started_reg      <= started_next;
        end
    end

endmodule

[design/grfp_queue.sv]
// Two-entry command queue between front and back end.
// Depends on grfp_pkg for the command type.
module grfp_queue
    import grfp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    output logic push_ready,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/grfp_back.sv]
// Back end: serializes a command to bytes, one per unstalled cycle, and runs the CRC.
// Depends on grfp_pkg.
module grfp_back
    import grfp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      pop_valid,
    input  cmd_t      pop_cmd,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    cmd_t             cmd_reg;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg;
    logic [15:0]      seed_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic             produce;
    logic             last_byte;
    logic [IDX_W-1:0] last_idx;
    logic [15:0]      crc_cur;
    logic [7:0]       rec_byte;
    out_item_t        out_next;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    assign produce   = busy_reg && (!m_valid_reg || m_ready);
    assign last_byte = (idx_reg == last_idx);
    assign pop       = pop_valid && (!busy_reg || (produce && last_byte));
    assign rec_byte  = cmd_reg.record[{idx_reg, 3'b000} +: 8];
    // The first record byte of a frame, or a header that opens one, starts from the seed.
    assign crc_cur   = (cmd_reg.start && (cmd_reg.kind == CMD_HEADER || idx_reg == '0))
                       ? seed_reg : crc_reg;

    always_comb begin
        out_next.byte_offset = '0;
        out_next.byte_value  = '0;
        out_next.status      = cmd_reg.status;
        out_next.last_of_run = last_byte;
        case (cmd_reg.kind)
            CMD_ROW: begin
                last_idx             = IDX_W'(REC_BYTES - 1);
                out_next.byte_offset = cmd_reg.base + OFF_W'(idx_reg);
                out_next.byte_value  = rec_byte;
            end
            CMD_HEADER: begin
                last_idx             = IDX_W'(HDR_BYTES - 1);
                out_next.byte_offset = OFF_W'(idx_reg);
                case (idx_reg[1:0])
                    2'd0:    out_next.byte_value = cfg.format_id;
                    2'd1:    out_next.byte_value = cfg.row_count;
                    2'd2:    out_next.byte_value = crc_cur[7:0];
                    default: out_next.byte_value = crc_cur[15:8];
                endcase
            end
            default: begin
                last_idx = '0;
            end
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (produce) begin
            busy_next = !last_byte;
            idx_next  = idx_reg + IDX_W'(1);
        end
    end

    // Seed holds the count byte; user changes row_count only while idle (not enforced).
    always_ff @(posedge aclk) begin
        seed_reg <= crc_fold(CRC_INIT, cfg.row_count);
        if (pop) begin
            cmd_reg <= pop_cmd;
        end
        if (produce && cmd_reg.kind == CMD_ROW) begin
            crc_reg <= crc_fold(crc_cur, rec_byte);
        end
        if (produce) begin
            m_data_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[design/guard_record_frame_packer_unit.sv]
// Guard record frame packer, top level: configuration registers, front end, queue, back end.
// Depends on grfp_pkg, grfp_front, grfp_queue and grfp_back.
//
// Usage:
//   s_valid/s_ready/s_payload carry requests: an append turns one guard row into
//   24 record bytes, a close emits the 4 header bytes (format, count, CRC low,
//   CRC high). A request that fails a check (count over limit, over capacity,
//   extra row, early close) gives one status result with offset and value zero.
//   m_valid/m_ready/m_payload carry one frame byte per transfer, tagged with its
//   offset; last_of_run marks the final transfer of a request.
//   cfg_wr_en/cfg_index/cfg_wr_data write row_count (0), format_id (1) and
//   buffer_capacity (2) while the block is idle; writing row_count drops any
//   frame in progress.
// Timing:
//   The first result of a request passes through the command queue, the back
//   end's command register and the output register. The back end emits one
//   byte per cycle while m_ready allows, so an append gives 24 bytes, a close 4
//   and an error 1; a two-entry command queue lets the front keep taking requests
//   meanwhile. The CRC advances one byte per unstalled cycle in the back end.
// Reset (aresetn low, synchronous): clears the queue, output valid, row
//   bookkeeping and configuration (row_count 0, format_id 0, capacity 388).
// Stall: when m_ready is low the output byte holds, the back end pauses, the
//   queue fills and s_ready drops.
module guard_record_frame_packer_unit
    import grfp_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_payload
);

    cfg_t cfg_reg, cfg_next;
    logic cfg_clear;
    logic push, push_ready, pop, pop_valid;
    cmd_t push_cmd, pop_cmd;

    // Writing row_count restarts the frame bookkeeping.
    assign cfg_clear = cfg_wr_en && (cfg_index == CFG_ROW_COUNT);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROW_COUNT: cfg_next.row_count       = cfg_wr_data[7:0];
                CFG_FORMAT_ID: cfg_next.format_id       = cfg_wr_data[7:0];
                CFG_CAPACITY:  cfg_next.buffer_capacity = cfg_wr_data;
                default:       cfg_next = cfg_reg;   // unmapped index: drop the write
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_count       <= 8'd0;
            cfg_reg.format_id       <= 8'd0;
            cfg_reg.buffer_capacity <= 10'd388;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify each request and book rows.
    grfp_front #(
        .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_clear),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .push      (push),
        .push_ready(push_ready),
        .push_cmd  (push_cmd)
    );

    // Decouple classification from byte emission.
    grfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_ready(push_ready),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    // Emit bytes and advance the CRC.
    grfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .pop_valid(pop_valid),
        .pop_cmd  (pop_cmd),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

endmodule

[design/grfp_checker.sv]
// Port-level checks for the guard record frame packer, bound to the top level.
// Depends on grfp_pkg and guard_record_frame_packer_unit.
module grfp_checker
    import grfp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_payload
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // Reset empties the output.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A status result is a lone, zeroed transfer.
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status != STAT_OK |->
            m_payload.last_of_run && m_payload.byte_offset == '0 &&
            m_payload.byte_value == '0)
        else $error("malformed status result");

    // A good run's last transfer ends the header (offset 3) or a record, which
    // puts it at offset 27 or above.
    a_ok_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status == STAT_OK && m_payload.last_of_run |->
            m_payload.byte_offset == 9'd3 || m_payload.byte_offset >= 9'd27)
        else $error("good run ended at a bad offset");

endmodule

bind guard_record_frame_packer_unit grfp_checker u_grfp_checker (.*);

[tb/sv/guard_record_frame_packer_unit_tb.sv]
// Self-checking testbench for guard_record_frame_packer_unit: drives guard rows and
// close requests, predicts every frame byte and status result, and checks the output.
// Depends on grfp_pkg and the design files of the frame packer.
module guard_record_frame_packer_unit_tb
    import grfp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LIMIT    = MAX_ROWS_DEF;
    localparam int ITEM_TARGET  = 360;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 6;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 600000;
    localparam int REPORT_MAX   = 10;

    // Payload fill styles for generated rows.
    localparam int FILL_RAND = 0;
    localparam int FILL_ONES = 1;
    localparam int FILL_ZERO = 2;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROW_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_payload = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_payload;

    guard_record_frame_packer_unit #(
        .MAX_ROWS(ROW_LIMIT)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Requests waiting for the driver, and frame bytes still owed by the block.
    in_item_t  pending_reqs[$];
    out_item_t expected_bytes[$];

    // Shadow of the packer: configuration registers and frame bookkeeping.
    logic [7:0]  shadow_rows;
    logic [7:0]  shadow_format;
    logic [9:0]  shadow_capacity;
    logic [15:0] shadow_crc;
    logic [7:0]  shadow_written;
    logic        shadow_open;

    // Idle control shared by the driver and the sink.
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    bit          no_idle       = 1'b0;
    int unsigned sink_hold_req = 0;
    int unsigned sink_hold_seen = 0;
    int unsigned sink_hold_left = 0;
    int unsigned sink_gap_left = 0;
    int unsigned src_gap_left  = 0;

    int unsigned fail_count   = 0;
    int unsigned queued_items = 0;
    int unsigned cycle_count  = 0;
    out_item_t   want;

    // CCITT-FALSE byte update, MSB first, one bit per step.
    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int k = 7; k >= 0; k--) begin
            fb  = acc[15] ^ b[k];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    function automatic out_item_t frame_byte(input int unsigned off, input logic [7:0] val,
                                             input logic [1:0] st, input logic last);
        out_item_t o;
        o.byte_offset = off[OFF_W-1:0];
        o.byte_value  = val;
        o.status      = st;
        o.last_of_run = last;
        return o;
    endfunction

    function automatic void clear_frame();
        shadow_crc     = CRC_INIT;
        shadow_written = '0;
        shadow_open    = 1'b0;
    endfunction

    // Fold the count byte in on the first successful request of a frame.
    function automatic void open_frame();
        if (!shadow_open) begin
            shadow_crc  = crc_ccitt_byte(CRC_INIT, shadow_rows);
            shadow_open = 1'b1;
        end
    endfunction

    // Work out the bytes one accepted request produces and queue them.
    function automatic void pack_request(input in_item_t req);
        logic [REC_BITS-1:0] rec;
        logic [7:0]          b;
        int unsigned         frame_size;
        int unsigned         base;
        frame_size = HDR_BYTES + REC_BYTES * int'(shadow_rows);
        if (int'(shadow_rows) > ROW_LIMIT) begin
            expected_bytes.push_back(frame_byte(0, 8'h00, STAT_COUNT, 1'b1));
        end else if (frame_size > int'(shadow_capacity)) begin
            expected_bytes.push_back(frame_byte(0, 8'h00, STAT_CAPACITY, 1'b1));
        end else if (req.req_type == REQ_CLOSE) begin
            if (shadow_written != shadow_rows) begin
                expected_bytes.push_back(frame_byte(0, 8'h00, STAT_MISMATCH, 1'b1));
            end else begin
                open_frame();
                expected_bytes.push_back(frame_byte(0, shadow_format, STAT_OK, 1'b0));
                expected_bytes.push_back(frame_byte(1, shadow_rows, STAT_OK, 1'b0));
                expected_bytes.push_back(frame_byte(2, shadow_crc[7:0], STAT_OK, 1'b0));
                expected_bytes.push_back(frame_byte(3, shadow_crc[15:8], STAT_OK, 1'b1));
                clear_frame();
            end
        end else if (shadow_written >= shadow_rows) begin
            expected_bytes.push_back(frame_byte(0, 8'h00, STAT_MISMATCH, 1'b1));
        end else begin
            open_frame();
            // Record image, byte i in bits 8i+7:8i.
            rec = {req.last_fire_time, req.window_start_time, req.window_fired,
                   req.hourly_cap, req.cooldown_seconds, 7'd0, req.lockout_flag,
                   req.action_code, req.key_high, req.key_low};
            base = HDR_BYTES + REC_BYTES * int'(shadow_written);
            for (int i = 0; i < REC_BYTES; i++) begin
                b = rec[8*i +: 8];
                shadow_crc = crc_ccitt_byte(shadow_crc, b);
                expected_bytes.push_back(frame_byte(base + i, b, STAT_OK, i == REC_BYTES - 1));
            end
            shadow_written = shadow_written + 8'd1;
        end
    endfunction

    function automatic in_item_t make_request(input logic kind, input int fill);
        in_item_t r;
        if (fill == FILL_ONES) begin
            r = '1;
        end else if (fill == FILL_ZERO) begin
            r = '0;
        end else begin
            r.key_low           = {$urandom, $urandom};
            r.key_high          = 16'($urandom_range(0, 16'hFFFF));
            r.action_code       = 8'($urandom_range(0, 8'hFF));
            r.lockout_flag      = 1'($urandom_range(0, 1));
            r.cooldown_seconds  = 16'($urandom_range(0, 16'hFFFF));
            r.hourly_cap        = 8'($urandom_range(0, 8'hFF));
            r.window_fired      = 8'($urandom_range(0, 8'hFF));
            r.window_start_time = $urandom;
            r.last_fire_time    = $urandom;
        end
        r.req_type = kind;
        return r;
    endfunction

    task automatic add_item(input logic kind, input int fill);
        pending_reqs.push_back(make_request(kind, fill));
        queued_items++;
    endtask

    // Hold until the driver is empty and every owed byte has been seen,
    // then let the block settle before anything is reconfigured.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_bytes.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // One register write; mirror it into the shadow state.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == CFG_ROW_COUNT) begin
            shadow_rows = val[7:0];
            clear_frame();
        end else if (idx == CFG_FORMAT_ID) begin
            shadow_format = val[7:0];
        end else begin
            shadow_capacity = val[9:0];
        end
        @(negedge aclk);
    endtask

    // Driver: hold the payload until the transfer, then either idle for a burst
    // or present the next pending request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pack_request(s_payload);
            end
            if (s_valid && !s_ready) begin
                // hold: payload stays put until accepted
            end else if (src_gap_left > 0) begin
                src_gap_left--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < src_idle_pct) begin
                src_gap_left = $urandom_range(0, 12);
                s_valid <= 1'b0;
            end else begin
                s_valid   <= 1'b1;
                s_payload <= pending_reqs.pop_front();
            end
        end
    end

    // Sink: random stall bursts, plus a long hold-off on request so the
    // command queue fills and s_ready drops.
    always @(posedge aclk) begin
        if (sink_hold_seen != sink_hold_req) begin
            sink_hold_seen = sink_hold_req;
            sink_hold_left = LONG_HOLD;
        end
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_ready <= 1'b0;
        end else if (sink_gap_left > 0) begin
            sink_gap_left--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < sink_idle_pct) begin
            sink_gap_left = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: compare each output transfer against the oldest owed byte.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("unexpected transfer: off=%0d val=%02h st=%0d last=%0b",
                             m_payload.byte_offset, m_payload.byte_value,
                             m_payload.status, m_payload.last_of_run);
                end
            end else begin
                want = expected_bytes.pop_front();
                if (m_payload.byte_offset !== want.byte_offset ||
                    m_payload.byte_value  !== want.byte_value  ||
                    m_payload.status      !== want.status      ||
                    m_payload.last_of_run !== want.last_of_run) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch exp off=%0d val=%02h st=%0d last=%0b",
                                 want.byte_offset, want.byte_value, want.status,
                                 want.last_of_run);
                        $display("         act off=%0d val=%02h st=%0d last=%0b",
                                 m_payload.byte_offset, m_payload.byte_value,
                                 m_payload.status, m_payload.last_of_run);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned pick;
        int unsigned rows_sel;
        int unsigned cap_sel;
        int unsigned need;
        int unsigned frames;
        int unsigned phase_no;
        int unsigned idle_levels[4];

        idle_levels = '{0, 10, 30, 60};
        shadow_rows     = '0;
        shadow_format   = '0;
        shadow_capacity = 10'd388;
        clear_frame();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset configuration. Empty frame, extra row, empty frame again.
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        add_item(REQ_CLOSE, FILL_RAND);
        add_item(REQ_APPEND, FILL_ONES);
        add_item(REQ_CLOSE, FILL_ZERO);
        wait_idle();

        // Count over limit, just above and at the top of the register.
        write_reg(CFG_ROW_COUNT, ROW_LIMIT + 1);
        add_item(REQ_APPEND, FILL_RAND);
        add_item(REQ_CLOSE, FILL_RAND);
        wait_idle();
        write_reg(CFG_ROW_COUNT, 255);
        add_item(REQ_APPEND, FILL_ONES);
        wait_idle();

        // Over capacity: full frame one byte too big, and zero capacity.
        write_reg(CFG_ROW_COUNT, ROW_LIMIT);
        write_reg(CFG_CAPACITY, HDR_BYTES + REC_BYTES * ROW_LIMIT - 1);
        add_item(REQ_APPEND, FILL_RAND);
        wait_idle();
        write_reg(CFG_ROW_COUNT, 0);
        write_reg(CFG_CAPACITY, 0);
        add_item(REQ_CLOSE, FILL_RAND);
        wait_idle();

        // Two-row frame with early closes, extreme payloads and an extra row.
        write_reg(CFG_ROW_COUNT, 2);
        write_reg(CFG_FORMAT_ID, 255);
        write_reg(CFG_CAPACITY, 1023);
        add_item(REQ_CLOSE, FILL_RAND);
        add_item(REQ_APPEND, FILL_ONES);
        add_item(REQ_CLOSE, FILL_RAND);
        add_item(REQ_APPEND, FILL_ZERO);
        add_item(REQ_APPEND, FILL_RAND);
        add_item(REQ_CLOSE, FILL_ONES);
        wait_idle();

        // Abandon a frame in progress by rewriting the row count.
        write_reg(CFG_ROW_COUNT, 3);
        add_item(REQ_APPEND, FILL_RAND);
        wait_idle();
        write_reg(CFG_ROW_COUNT, 1);
        write_reg(CFG_FORMAT_ID, 0);
        add_item(REQ_APPEND, FILL_RAND);
        add_item(REQ_CLOSE, FILL_RAND);
        wait_idle();

        // Random phases: mostly well-formed frames, some noise and error configs.
        phase_no = 0;
        while (queued_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (phase_no == 0) begin
                rows_sel = ROW_LIMIT;
            end else if (phase_no == 2) begin
                rows_sel = 6;
            end else if (pick < 6) begin
                rows_sel = $urandom_range(ROW_LIMIT + 1, 255);
            end else if ($urandom_range(0, 99) < 12) begin
                rows_sel = $urandom_range(7, ROW_LIMIT);
            end else begin
                rows_sel = $urandom_range(0, 6);
            end
            need = HDR_BYTES + REC_BYTES * rows_sel;
            if (pick >= 6 && pick < 12 && phase_no > 2) begin
                cap_sel = $urandom_range(0, need - 1);
            end else if (need > 1023) begin
                cap_sel = $urandom_range(0, 1023);
            end else if ($urandom_range(0, 3) == 0) begin
                cap_sel = need;
            end else begin
                cap_sel = $urandom_range(need, 1023);
            end
            write_reg(CFG_FORMAT_ID, $urandom_range(0, 255));
            write_reg(CFG_CAPACITY, cap_sel);
            write_reg(CFG_ROW_COUNT, rows_sel);

            // Drop all idling near the end of the run.
            no_idle       = (queued_items > ITEM_TARGET - 60);
            src_idle_pct  = idle_levels[$urandom_range(0, 3)];
            sink_idle_pct = idle_levels[$urandom_range(0, 3)];

            if (rows_sel > ROW_LIMIT || need > cap_sel) begin
                repeat ($urandom_range(2, 5)) add_item(1'($urandom_range(0, 1)), FILL_RAND);
            end else begin
                frames = $urandom_range(1, 3);
                for (int f = 0; f < frames; f++) begin
                    for (int r = 0; r < rows_sel; r++) begin
                        if ($urandom_range(0, 99) < 6) add_item(REQ_CLOSE, FILL_RAND);
                        add_item(REQ_APPEND, FILL_RAND);
                    end
                    if ($urandom_range(0, 99) < 8) add_item(REQ_APPEND, FILL_RAND);
                    add_item(REQ_CLOSE, FILL_RAND);
                end
            end

            // Long sink hold-off while the driver keeps offering rows.
            if (phase_no == 2) sink_hold_req++;
            wait_idle();
            phase_no++;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_bytes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
